@@ hdl/modexp_pkg.sv @@
// Shared constants and types of the modular exponentiation block.
package modexp_pkg;

   // Width of the modulus and of every residue.
   localparam int MODULUS_BITS = 31;
   // Modulus after reset, cut to the residue width.
   localparam logic [MODULUS_BITS-1:0] MODULUS_RESET = MODULUS_BITS'(1000000007);

   // Input word fields.
   localparam int OPERAND_BITS = 64;
   localparam int REQ_DATA_BITS = 2 * OPERAND_BITS;
   // Result word, padded to whole bytes.
   localparam int RSP_DATA_BITS = ((MODULUS_BITS + 7) / 8) * 8;

   // Bit counters of the remainder and multiplier iterations.
   localparam int REDUCE_CNT_BITS = $clog2(OPERAND_BITS);
   localparam int MUL_CNT_BITS = (MODULUS_BITS > 2) ? $clog2(MODULUS_BITS) : 1;

   // Sequencer states.
   typedef enum logic [6:0] {
      ST_IDLE     = 7'b0000001,
      ST_REDUCE   = 7'b0000010,
      ST_FIXUP    = 7'b0000100,
      ST_STEP     = 7'b0001000,
      ST_MUL      = 7'b0010000,
      ST_LOOP_END = 7'b0100000,
      ST_FINISH   = 7'b1000000
   } state_type;

   // Destination of a finished modular product.
   typedef enum logic {
      DEST_PRODUCT = 1'b0,
      DEST_SQUARE  = 1'b1
   } mul_dest_type;

endpackage

@@ hdl/modular_exponentiation.sv @@
// Modular exponentiation top level: square-and-multiply over one shared modular multiplier.
//
// Each request word carries a signed 64-bit base and a signed 64-bit exponent; the block
// answers with one word holding base^exponent mod modulus. The base is first reduced by a
// bit-serial remainder unit, then every modular multiplication runs through a single
// interleaved shift-add multiplier that retires one multiplier bit per cycle, with a
// sequencing step between multiplications. An exponent of magnitude e costs about
// (bit length of e + number of set bits of e) multiplications; a negative exponent adds
// a second pass raising the result to modulus-2, a Fermat inverse that is correct only
// for a prime modulus. A zero modulus skips the reduction and goes straight to the finish;
// otherwise, with a 31-bit modulus, a full item needs at most 186 multiplications.
// req_tready is high only while the block is idle; a finished result waits in the output
// register, so a new request may be taken before it drains. A zero modulus or a base that
// reduces to zero gives 0. The user must write the modulus through the csr port only while
// no request is in flight; the block does not enforce this. Its reset value is 1000000007.
module modular_exponentiation (
   input  logic                                   clock,
   input  logic                                   reset,
   // Request channel
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   // [63:0] base_value, [127:64] exponent
   input  logic [modexp_pkg::REQ_DATA_BITS-1:0]   req_tdata,
   // Result channel
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   // [MODULUS_BITS-1:0] power_result, zero padding above
   output logic [modexp_pkg::RSP_DATA_BITS-1:0]   rsp_tdata,
   // Modulus write channel
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [modexp_pkg::MODULUS_BITS-1:0]    csr_data
);

   localparam int MB = modexp_pkg::MODULUS_BITS;
   localparam int OB = modexp_pkg::OPERAND_BITS;
   localparam int RCB = modexp_pkg::REDUCE_CNT_BITS;
   localparam int MCB = modexp_pkg::MUL_CNT_BITS;

   modexp_pkg::state_type    state_ff, state_in;
   modexp_pkg::mul_dest_type mul_dest_ff, mul_dest_in;

   logic [MB-1:0]  modulus_ff, modulus_in;
   logic [OB-1:0]  base_mag_ff, base_mag_in;
   logic [OB-1:0]  exp_mag_ff, exp_mag_in;
   logic           base_neg_ff, base_neg_in;
   logic           exp_neg_ff, exp_neg_in;
   logic [MB-1:0]  rem_ff, rem_in;
   logic [RCB-1:0] red_cnt_ff, red_cnt_in;
   logic [MB-1:0]  product_ff, product_in;
   logic [MB-1:0]  square_ff, square_in;
   logic           inverse_ff, inverse_in;
   logic           prod_done_ff, prod_done_in;
   logic [MB-1:0]  mul_a_ff, mul_a_in;
   logic [MB-1:0]  mul_b_ff, mul_b_in;
   logic [MB-1:0]  acc_ff, acc_in;
   logic [MCB-1:0] mul_cnt_ff, mul_cnt_in;
   logic [MB-1:0]  result_ff, result_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic [MB-1:0]  rsp_data_ff, rsp_data_in;

   // Datapath helpers
   logic [OB-1:0]  raw_base;
   logic [OB-1:0]  raw_exp;
   logic [MB:0]    rem_ext;
   logic [MB-1:0]  rem_next;
   logic [MB-1:0]  rem_fixed;
   logic [MB:0]    dbl;
   logic [MB-1:0]  dbl_red;
   logic [MB:0]    add_sum;
   logic [MB-1:0]  add_red;
   logic [MB:0]    mod_ext;

   assign raw_base = req_tdata[OB-1:0];
   assign raw_exp  = req_tdata[2*OB-1:OB];
   assign mod_ext  = {1'b0, modulus_ff};

   assign req_tready = (state_ff == modexp_pkg::ST_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = modexp_pkg::RSP_DATA_BITS'(rsp_data_ff);

   // Restoring remainder step: shift in the next base bit, subtract the modulus if it fits
   always_comb begin
      rem_ext = {rem_ff, base_mag_ff[OB-1]};
      if (rem_ext >= mod_ext) begin
         rem_next = MB'(rem_ext - mod_ext);
      end else begin
         rem_next = rem_ext[MB-1:0];
      end
   end

   // Move a negative remainder up by the modulus
   always_comb begin
      if (base_neg_ff && (rem_ff != '0)) begin
         rem_fixed = modulus_ff - rem_ff;
      end else begin
         rem_fixed = rem_ff;
      end
   end

   // Interleaved multiplier step: acc = 2*acc + bit*a, kept below the modulus
   always_comb begin
      dbl = {acc_ff, 1'b0};
      if (dbl >= mod_ext) begin
         dbl_red = MB'(dbl - mod_ext);
      end else begin
         dbl_red = dbl[MB-1:0];
      end
      add_sum = {1'b0, dbl_red} + (mul_b_ff[MB-1] ? {1'b0, mul_a_ff} : '0);
      if (add_sum >= mod_ext) begin
         add_red = MB'(add_sum - mod_ext);
      end else begin
         add_red = add_sum[MB-1:0];
      end
   end

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      mul_dest_in  = mul_dest_ff;
      modulus_in   = modulus_ff;
      base_mag_in  = base_mag_ff;
      exp_mag_in   = exp_mag_ff;
      base_neg_in  = base_neg_ff;
      exp_neg_in   = exp_neg_ff;
      rem_in       = rem_ff;
      red_cnt_in   = red_cnt_ff;
      product_in   = product_ff;
      square_in    = square_ff;
      inverse_in   = inverse_ff;
      prod_done_in = prod_done_ff;
      mul_a_in     = mul_a_ff;
      mul_b_in     = mul_b_ff;
      acc_in       = acc_ff;
      mul_cnt_in   = mul_cnt_ff;
      result_in    = result_ff;
      rsp_data_in  = rsp_data_ff;

      // Drop the result word once taken
      rsp_valid_in = rsp_valid_ff && !rsp_tready;

      // Take a modulus write
      if (csr_valid) begin
         modulus_in = csr_data;
      end

      unique case (state_ff)
         modexp_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               base_neg_in = raw_base[OB-1];
               exp_neg_in  = raw_exp[OB-1];
               base_mag_in = raw_base[OB-1] ? (OB'(0) - raw_base) : raw_base;
               exp_mag_in  = raw_exp[OB-1] ? (OB'(0) - raw_exp) : raw_exp;
               inverse_in  = 1'b0;
               rem_in      = '0;
               red_cnt_in  = RCB'(OB - 1);
               if (modulus_ff == '0) begin
                  result_in = '0;
                  state_in  = modexp_pkg::ST_FINISH;
               end else begin
                  state_in  = modexp_pkg::ST_REDUCE;
               end
            end
         end
         modexp_pkg::ST_REDUCE: begin
            rem_in      = rem_next;
            base_mag_in = {base_mag_ff[OB-2:0], 1'b0};
            red_cnt_in  = red_cnt_ff - 1'b1;
            if (red_cnt_ff == '0) begin
               state_in = modexp_pkg::ST_FIXUP;
            end
         end
         modexp_pkg::ST_FIXUP: begin
            if (rem_fixed == '0) begin
               result_in = '0;
               state_in  = modexp_pkg::ST_FINISH;
            end else begin
               square_in    = rem_fixed;
               product_in   = MB'(1);
               prod_done_in = 1'b0;
               state_in     = modexp_pkg::ST_STEP;
            end
         end
         modexp_pkg::ST_STEP: begin
            mul_cnt_in = MCB'(MB - 1);
            acc_in     = '0;
            if (exp_mag_ff == '0) begin
               state_in = modexp_pkg::ST_LOOP_END;
            end else if (exp_mag_ff[0] && !prod_done_ff) begin
               // Fold the current square into the product
               mul_a_in    = product_ff;
               mul_b_in    = square_ff;
               mul_dest_in = modexp_pkg::DEST_PRODUCT;
               state_in    = modexp_pkg::ST_MUL;
            end else if (exp_mag_ff[OB-1:1] == '0) begin
               // Last bit consumed: skip the unused square
               exp_mag_in   = '0;
               prod_done_in = 1'b0;
            end else begin
               mul_a_in    = square_ff;
               mul_b_in    = square_ff;
               mul_dest_in = modexp_pkg::DEST_SQUARE;
               state_in    = modexp_pkg::ST_MUL;
            end
         end
         modexp_pkg::ST_MUL: begin
            acc_in     = add_red;
            mul_b_in   = {mul_b_ff[MB-2:0], 1'b0};
            mul_cnt_in = mul_cnt_ff - 1'b1;
            if (mul_cnt_ff == '0) begin
               state_in = modexp_pkg::ST_STEP;
               unique case (mul_dest_ff)
                  modexp_pkg::DEST_PRODUCT: begin
                     product_in   = add_red;
                     prod_done_in = 1'b1;
                  end
                  modexp_pkg::DEST_SQUARE: begin
                     square_in    = add_red;
                     exp_mag_in   = {1'b0, exp_mag_ff[OB-1:1]};
                     prod_done_in = 1'b0;
                  end
                  default: begin
                     prod_done_in = 1'b0;
                  end
               endcase
            end
         end
         modexp_pkg::ST_LOOP_END: begin
            if (exp_neg_ff && !inverse_ff && (product_ff != '0)) begin
               // Fermat inverse: raise the result to modulus-2
               inverse_in   = 1'b1;
               square_in    = product_ff;
               product_in   = MB'(1);
               exp_mag_in   = OB'(modulus_ff - MB'(2));
               prod_done_in = 1'b0;
               state_in     = modexp_pkg::ST_STEP;
            end else begin
               result_in = product_ff;
               state_in  = modexp_pkg::ST_FINISH;
            end
         end
         modexp_pkg::ST_FINISH: begin
            // Hold until the output register is free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = result_ff;
               state_in     = modexp_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = modexp_pkg::ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= modexp_pkg::ST_IDLE;
         modulus_ff   <= modexp_pkg::MODULUS_RESET;
         rsp_valid_ff <= 1'b0;
         product_ff   <= MB'(1);
         square_ff    <= '0;
         exp_mag_ff   <= '0;
         inverse_ff   <= 1'b0;
         prod_done_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         modulus_ff   <= modulus_in;
         rsp_valid_ff <= rsp_valid_in;
         product_ff   <= product_in;
         square_ff    <= square_in;
         exp_mag_ff   <= exp_mag_in;
         inverse_ff   <= inverse_in;
         prod_done_ff <= prod_done_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      mul_dest_ff <= mul_dest_in;
      base_mag_ff <= base_mag_in;
      base_neg_ff <= base_neg_in;
      exp_neg_ff  <= exp_neg_in;
      rem_ff      <= rem_in;
      red_cnt_ff  <= red_cnt_in;
      mul_a_ff    <= mul_a_in;
      mul_b_ff    <= mul_b_in;
      acc_ff      <= acc_in;
      mul_cnt_ff  <= mul_cnt_in;
      result_ff   <= result_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule
